// ----- hdl/hrhp_pkg.sv -----
package hrhp_pkg;

    // parse phases
    localparam logic [1:0] PH_STATUS  = 2'd0;
    localparam logic [1:0] PH_HEADERS = 2'd1;
    localparam logic [1:0] PH_BODY    = 2'd2;
    localparam logic [1:0] PH_BAD     = 2'd3;

    // number scanner states
    localparam logic [1:0] NS_BEFORE  = 2'd0;
    localparam logic [1:0] NS_SIGN    = 2'd1;
    localparam logic [1:0] NS_DIGITS  = 2'd2;
    localparam logic [1:0] NS_STOPPED = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_BODY = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    localparam logic [3:0]  STATUS_PFX_LEN = 4'd8;
    localparam logic [3:0]  CLEN_PFX_LEN   = 4'd15;
    localparam logic [31:0] MAG_CAP        = 32'h8000_0000;
    localparam logic [31:0] LEN_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] STATUS_POS_MAX = 32'd32767;
    localparam logic [31:0] STATUS_NEG_MAX = 32'd32768;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [1:0]  phase;
        logic        prev_cr;
        logic [3:0]  match_pos;
        logic [1:0]  num_state;
        logic        num_neg;
        logic [31:0] acc;
        logic [15:0] status;
        logic [30:0] length;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] status_code;
        logic [30:0] content_length;
        logic [7:0]  body_byte;
    } result_t;

    function automatic logic [7:0] status_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = "H";
            4'd1:    ch = "T";
            4'd2:    ch = "T";
            4'd3:    ch = "P";
            4'd4:    ch = "/";
            4'd5:    ch = "1";
            4'd6:    ch = ".";
            4'd7:    ch = "1";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = "C";
            4'd1:    ch = "O";
            4'd2:    ch = "N";
            4'd3:    ch = "T";
            4'd4:    ch = "E";
            4'd5:    ch = "N";
            4'd6:    ch = "T";
            4'd7:    ch = "-";
            4'd8:    ch = "L";
            4'd9:    ch = "E";
            4'd10:   ch = "N";
            4'd11:   ch = "G";
            4'd12:   ch = "T";
            4'd13:   ch = "H";
            4'd14:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

// ----- hdl/hrhp_step.sv -----
module hrhp_step #(
    parameter int LINE_BUF_BYTES = 256,
    localparam int LC_W = $clog2(LINE_BUF_BYTES - 1)
) (
    input  logic                  op,
    input  logic [7:0]            byte_in,
    input  hrhp_pkg::parse_state_t st,
    input  logic [LC_W-1:0]       lc,
    output hrhp_pkg::parse_state_t st_next,
    output logic [LC_W-1:0]       lc_next,
    output hrhp_pkg::result_t     res
);

    localparam logic [LC_W-1:0] LINE_LIMIT = LC_W'(LINE_BUF_BYTES - 2);
    localparam logic [LC_W-1:0] LC_ONE     = LC_W'(1);

    always_comb
    begin
        logic        is_status;
        logic [3:0]  plen;
        logic [7:0]  exp_ch;
        logic [7:0]  u;
        logic        digit;
        logic [3:0]  d;
        logic [35:0] v;
        logic [31:0] acc_sat;
        logic        ok;
        logic [31:0] m;
        logic [31:0] neg_val;

        is_status = (st.phase == hrhp_pkg::PH_STATUS);
        plen      = is_status ? hrhp_pkg::STATUS_PFX_LEN : hrhp_pkg::CLEN_PFX_LEN;
        exp_ch    = is_status ? hrhp_pkg::status_char(st.match_pos)
                              : hrhp_pkg::clen_char(st.match_pos);
        u         = (!is_status && byte_in >= "a" && byte_in <= "z")
                    ? byte_in - 8'd32 : byte_in;
        digit     = (byte_in >= "0" && byte_in <= "9");
        d         = byte_in[3:0];
        v         = ({4'd0, st.acc} << 3) + ({4'd0, st.acc} << 1) + {32'd0, d};
        acc_sat   = (v >= {4'd0, hrhp_pkg::MAG_CAP}) ? hrhp_pkg::MAG_CAP : v[31:0];
        ok        = (st.match_pos == plen) &&
                    (st.num_state == hrhp_pkg::NS_DIGITS ||
                     st.num_state == hrhp_pkg::NS_STOPPED);
        m         = (st.acc > hrhp_pkg::STATUS_NEG_MAX) ? hrhp_pkg::STATUS_NEG_MAX : st.acc;
        neg_val   = 32'd0 - m;

        st_next       = st;
        lc_next       = lc;
        res.kind      = hrhp_pkg::KIND_HDR;
        res.body_byte = 8'd0;

        if (op)
        begin
            st_next = '0;
            lc_next = '0;
        end
        else if (st.phase == hrhp_pkg::PH_BODY)
        begin
            res.kind      = hrhp_pkg::KIND_BODY;
            res.body_byte = byte_in;
        end
        else if (st.phase == hrhp_pkg::PH_BAD)
        begin
            res.kind = hrhp_pkg::KIND_BAD;
        end
        else if (st.prev_cr && byte_in == hrhp_pkg::CH_LF)
        begin
            if (is_status)
            begin
                if (ok)
                begin
                    if (st.num_neg)
                        st_next.status = neg_val[15:0];
                    else if (st.acc > hrhp_pkg::STATUS_POS_MAX)
                        st_next.status = hrhp_pkg::STATUS_POS_MAX[15:0];
                    else
                        st_next.status = st.acc[15:0];
                    st_next.phase = hrhp_pkg::PH_HEADERS;
                end
                else
                begin
                    st_next.phase = hrhp_pkg::PH_BAD;
                    res.kind      = hrhp_pkg::KIND_BAD;
                end
            end
            else if (lc == LC_ONE)
            begin
                // empty line: headers done
                st_next.phase = hrhp_pkg::PH_BODY;
                res.kind      = hrhp_pkg::KIND_DONE;
            end
            else if (ok && (!st.num_neg || st.acc == 32'd0))
            begin
                st_next.length = (st.acc > hrhp_pkg::LEN_MAX)
                                 ? hrhp_pkg::LEN_MAX[30:0] : st.acc[30:0];
            end
            lc_next           = '0;
            st_next.match_pos = 4'd0;
            st_next.num_state = hrhp_pkg::NS_BEFORE;
            st_next.num_neg   = 1'b0;
            st_next.acc       = 32'd0;
            st_next.prev_cr   = 1'b0;
        end
        else
        begin
            // bytes beyond the line limit only take part in CR LF detection
            if (lc < LINE_LIMIT)
            begin
                lc_next = lc + LC_ONE;
                if (st.num_state != hrhp_pkg::NS_STOPPED)
                begin
                    if (st.match_pos < plen)
                    begin
                        if (u == exp_ch)
                            st_next.match_pos = st.match_pos + 4'd1;
                        else
                            st_next.num_state = hrhp_pkg::NS_STOPPED;
                    end
                    else
                    begin
                        unique case (st.num_state)
                            hrhp_pkg::NS_BEFORE:
                            begin
                                if (hrhp_pkg::is_space(byte_in))
                                begin
                                    st_next.num_state = st.num_state;
                                end
                                else if (byte_in == hrhp_pkg::CH_PLUS ||
                                         byte_in == hrhp_pkg::CH_MINUS)
                                begin
                                    st_next.num_neg   = (byte_in == hrhp_pkg::CH_MINUS);
                                    st_next.num_state = hrhp_pkg::NS_SIGN;
                                end
                                else if (digit)
                                begin
                                    st_next.acc       = {28'd0, d};
                                    st_next.num_state = hrhp_pkg::NS_DIGITS;
                                end
                                else
                                begin
                                    st_next.num_state = hrhp_pkg::NS_STOPPED;
                                    st_next.match_pos = 4'd0;
                                end
                            end
                            hrhp_pkg::NS_SIGN:
                            begin
                                if (digit)
                                begin
                                    st_next.acc       = {28'd0, d};
                                    st_next.num_state = hrhp_pkg::NS_DIGITS;
                                end
                                else
                                begin
                                    st_next.num_state = hrhp_pkg::NS_STOPPED;
                                    st_next.match_pos = 4'd0;
                                end
                            end
                            default:
                            begin
                                if (digit)
                                    st_next.acc = acc_sat;
                                else
                                    st_next.num_state = hrhp_pkg::NS_STOPPED;
                            end
                        endcase
                    end
                end
            end
            st_next.prev_cr = (byte_in == hrhp_pkg::CH_CR);
        end

        res.status_code    = st_next.status;
        res.content_length = st_next.length;
    end

endmodule

// ----- hdl/http_response_header_parser.sv -----
// The result of an accepted input transaction is registered for the master side and
// is shown in the next cycle. Throughput: one byte per cycle unless m_tready stalls;
// the per-byte path is the parse-state update with the shift-add multiply by ten on
// the 32-bit accumulator. Reset: asynchronous, active low; clears the parse state
// and the output valid. No clearing pass is needed after reset.
module http_response_header_parser #(
    parameter int LINE_BUF_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] status_code, [46:16] content_length,
                                   // [54:47] body_byte, [55] zero
    output logic [1:0]  m_tuser    // [1:0] kind
);

    localparam int LC_W = $clog2(LINE_BUF_BYTES - 1);

    hrhp_pkg::parse_state_t state_reg;
    hrhp_pkg::parse_state_t state_next;
    logic [LC_W-1:0]        lc_reg;
    logic [LC_W-1:0]        lc_next;
    hrhp_pkg::result_t      result_reg;
    hrhp_pkg::result_t      result_next;
    logic                   m_valid_reg;
    logic                   accept;

    hrhp_step #(
        .LINE_BUF_BYTES(LINE_BUF_BYTES)
    ) u_step (
        .op      (s_tuser[0]),
        .byte_in (s_tdata),
        .st      (state_reg),
        .lc      (lc_reg),
        .st_next (state_next),
        .lc_next (lc_next),
        .res     (result_next)
    );

    // take a new transaction whenever the output slot frees this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            lc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg   <= state_next;
                lc_reg      <= lc_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, result_reg.body_byte, result_reg.content_length,
                       result_reg.status_code};
    assign m_tuser  = result_reg.kind;

endmodule

// ----- hdl/hrhp_checker.sv -----
module hrhp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input side opens exactly when the output slot frees
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output slot");

    // a restart answers with an all-zero header result in the next cycle
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=>
            m_tvalid && m_tdata == 56'd0 && m_tuser == hrhp_pkg::KIND_HDR)
        else $error("restart result not cleared");

    // body byte field only carries data for body results
    a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != hrhp_pkg::KIND_BODY |-> m_tdata[54:47] == 8'd0)
        else $error("body byte set outside body");

endmodule

bind http_response_header_parser hrhp_checker u_hrhp_checker (.*);

// ----- test/http_response_header_parser_tb.sv -----
`timescale 1ns / 100ps

module http_response_header_parser_tb;

    localparam int LINE_BUF     = 256;
    localparam int LINE_LIMIT   = LINE_BUF - 2;
    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_LIMIT   = 2000;

    localparam logic [8*8-1:0]  STATUS_TEXT = "HTTP/1.1";
    localparam logic [15*8-1:0] CLEN_TEXT   = "CONTENT-LENGTH:";
    // space, TAB, LF, VT, FF, CR
    localparam logic [6*8-1:0]  WS_SET      = {8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};

    localparam logic [15:0] SAT_NEG = 16'h8000;

    typedef struct packed {
        logic              op;
        logic [7:0]        octet;
        logic              typed;
        hrhp_pkg::result_t want;
    } stim_row_t;

    localparam int N_ROWS = 27;
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        '{1'b1, 8'h00, 1'b1, '{hrhp_pkg::KIND_HDR, 16'h0000, 31'd0, 8'h00}},
        '{1'b0, "X",   1'b0, '0},
        '{1'b0, hrhp_pkg::CH_CR, 1'b0, '0},
        '{1'b0, hrhp_pkg::CH_LF, 1'b1, '{hrhp_pkg::KIND_BAD, 16'h0000, 31'd0, 8'h00}},
        '{1'b0, 8'hFF, 1'b1, '{hrhp_pkg::KIND_BAD, 16'h0000, 31'd0, 8'h00}},
        '{1'b1, 8'hFF, 1'b1, '{hrhp_pkg::KIND_HDR, 16'h0000, 31'd0, 8'h00}},
        '{1'b0, "H",   1'b0, '0},
        '{1'b0, "T",   1'b0, '0},
        '{1'b0, "T",   1'b0, '0},
        '{1'b0, "P",   1'b0, '0},
        '{1'b0, "/",   1'b0, '0},
        '{1'b0, "1",   1'b0, '0},
        '{1'b0, ".",   1'b0, '0},
        '{1'b0, "1",   1'b0, '0},
        '{1'b0, " ",   1'b0, '0},
        '{1'b0, "-",   1'b0, '0},
        '{1'b0, "9",   1'b0, '0},
        '{1'b0, "9",   1'b0, '0},
        '{1'b0, "9",   1'b0, '0},
        '{1'b0, "9",   1'b0, '0},
        '{1'b0, "9",   1'b0, '0},
        '{1'b0, hrhp_pkg::CH_CR, 1'b0, '0},
        '{1'b0, hrhp_pkg::CH_LF, 1'b1, '{hrhp_pkg::KIND_HDR,  SAT_NEG, 31'd0, 8'h00}},
        '{1'b0, hrhp_pkg::CH_CR, 1'b0, '0},
        '{1'b0, hrhp_pkg::CH_LF, 1'b1, '{hrhp_pkg::KIND_DONE, SAT_NEG, 31'd0, 8'h00}},
        '{1'b0, 8'h00, 1'b1, '{hrhp_pkg::KIND_BODY, SAT_NEG, 31'd0, 8'h00}},
        '{1'b0, 8'hFF, 1'b1, '{hrhp_pkg::KIND_BODY, SAT_NEG, 31'd0, 8'hFF}}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    // parser state mirror
    logic [1:0]  st_phase;
    logic        st_cr;
    int unsigned st_chars;
    logic [3:0]  st_match;
    logic [1:0]  st_num;
    logic        st_neg;
    logic [31:0] st_acc;
    logic [15:0] st_status;
    logic [30:0] st_len;

    hrhp_pkg::result_t outcome_q [$];
    logic [8:0]        tx_q [$];

    int      fail_count = 0;
    int      sent_count = 0;
    int      burst_left = 0;
    int      idle_cycles = 0;
    int      ready_left = 0;
    logic [15:0] ready_pat = '1;
    hrhp_pkg::result_t got;
    hrhp_pkg::result_t want;

    http_response_header_parser #(
        .LINE_BUF_BYTES(LINE_BUF)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #2 clk = ~clk;

    function automatic void line_reset();
        st_chars = 0;
        st_match = '0;
        st_num   = hrhp_pkg::NS_BEFORE;
        st_neg   = 1'b0;
        st_acc   = '0;
    endfunction

    function automatic void parse_reset();
        st_phase  = hrhp_pkg::PH_STATUS;
        st_cr     = 1'b0;
        line_reset();
        st_status = '0;
        st_len    = '0;
    endfunction

    function automatic logic number_done(input logic [3:0] plen);
        return st_match == plen &&
               (st_num == hrhp_pkg::NS_DIGITS || st_num == hrhp_pkg::NS_STOPPED);
    endfunction

    function automatic hrhp_pkg::result_t parse_octet(input logic op,
                                                      input logic [7:0] octet);
        hrhp_pkg::result_t r;
        logic [31:0] mag;
        logic [31:0] wrapped;
        logic [63:0] wide;
        logic [3:0]  plen;
        logic [7:0]  folded;
        logic [7:0]  pfx_ch;
        logic        is_dig;
        logic        is_ws;
        logic        in_hdr;
        r.kind      = hrhp_pkg::KIND_HDR;
        r.body_byte = '0;
        is_dig = octet >= "0" && octet <= "9";
        is_ws  = octet == 8'd32 || (octet >= 8'd9 && octet <= 8'd13);
        in_hdr = (st_phase == hrhp_pkg::PH_HEADERS);
        if (op)
        begin
            parse_reset();
        end
        else if (st_phase == hrhp_pkg::PH_BODY)
        begin
            r.kind      = hrhp_pkg::KIND_BODY;
            r.body_byte = octet;
        end
        else if (st_phase == hrhp_pkg::PH_BAD)
        begin
            r.kind = hrhp_pkg::KIND_BAD;
        end
        else if (st_cr && octet == hrhp_pkg::CH_LF)
        begin
            if (st_phase == hrhp_pkg::PH_STATUS)
            begin
                if (number_done(hrhp_pkg::STATUS_PFX_LEN))
                begin
                    mag = st_acc;
                    if (st_neg)
                    begin
                        if (mag > hrhp_pkg::STATUS_NEG_MAX)
                            mag = hrhp_pkg::STATUS_NEG_MAX;
                        wrapped   = 32'h0001_0000 - mag;
                        st_status = wrapped[15:0];
                    end
                    else
                    begin
                        st_status = (mag > hrhp_pkg::STATUS_POS_MAX)
                                    ? hrhp_pkg::STATUS_POS_MAX[15:0] : mag[15:0];
                    end
                    st_phase = hrhp_pkg::PH_HEADERS;
                end
                else
                begin
                    st_phase = hrhp_pkg::PH_BAD;
                    r.kind   = hrhp_pkg::KIND_BAD;
                end
            end
            else if (st_chars == 1)
            begin
                st_phase = hrhp_pkg::PH_BODY;
                r.kind   = hrhp_pkg::KIND_DONE;
            end
            else if (number_done(hrhp_pkg::CLEN_PFX_LEN) && (!st_neg || st_acc == 0))
            begin
                st_len = (st_acc > hrhp_pkg::LEN_MAX) ? hrhp_pkg::LEN_MAX[30:0]
                                                      : st_acc[30:0];
            end
            line_reset();
            st_cr = 1'b0;
        end
        else
        begin
            // bytes past the line buffer only matter for finding CR LF
            if (st_chars < LINE_LIMIT)
            begin
                plen = in_hdr ? hrhp_pkg::CLEN_PFX_LEN : hrhp_pkg::STATUS_PFX_LEN;
                if (st_num != hrhp_pkg::NS_STOPPED)
                begin
                    if (st_match < plen)
                    begin
                        folded = octet;
                        if (in_hdr && octet >= "a" && octet <= "z")
                            folded = octet - 8'd32;
                        pfx_ch = in_hdr ? CLEN_TEXT[8*(14-st_match) +: 8]
                                        : STATUS_TEXT[8*(7-st_match) +: 8];
                        if (folded == pfx_ch)
                            st_match = st_match + 4'd1;
                        else
                            st_num = hrhp_pkg::NS_STOPPED;
                    end
                    else
                    begin
                        case (st_num)
                            hrhp_pkg::NS_BEFORE:
                            begin
                                if (!is_ws)
                                begin
                                    if (octet == hrhp_pkg::CH_PLUS ||
                                        octet == hrhp_pkg::CH_MINUS)
                                    begin
                                        st_neg = (octet == hrhp_pkg::CH_MINUS);
                                        st_num = hrhp_pkg::NS_SIGN;
                                    end
                                    else if (is_dig)
                                    begin
                                        st_acc = {28'd0, octet[3:0]};
                                        st_num = hrhp_pkg::NS_DIGITS;
                                    end
                                    else
                                    begin
                                        st_num   = hrhp_pkg::NS_STOPPED;
                                        st_match = '0;
                                    end
                                end
                            end
                            hrhp_pkg::NS_SIGN:
                            begin
                                if (is_dig)
                                begin
                                    st_acc = {28'd0, octet[3:0]};
                                    st_num = hrhp_pkg::NS_DIGITS;
                                end
                                else
                                begin
                                    st_num   = hrhp_pkg::NS_STOPPED;
                                    st_match = '0;
                                end
                            end
                            default:
                            begin
                                if (is_dig)
                                begin
                                    wide   = {32'd0, st_acc} * 64'd10 + {60'd0, octet[3:0]};
                                    st_acc = (wide >= {32'd0, hrhp_pkg::MAG_CAP})
                                             ? hrhp_pkg::MAG_CAP : wide[31:0];
                                end
                                else
                                begin
                                    st_num = hrhp_pkg::NS_STOPPED;
                                end
                            end
                        endcase
                    end
                end
                st_chars++;
            end
            st_cr = (octet == hrhp_pkg::CH_CR);
        end
        r.status_code    = st_status;
        r.content_length = st_len;
        return r;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            tx_q.push_back({1'b0, s.getc(i)});
    endfunction

    function automatic void push_eol();
        tx_q.push_back({1'b0, hrhp_pkg::CH_CR});
        tx_q.push_back({1'b0, hrhp_pkg::CH_LF});
    endfunction

    function automatic void push_ws();
        repeat ($urandom_range(0, 3))
            tx_q.push_back({1'b0, WS_SET[8*$urandom_range(0, 5) +: 8]});
    endfunction

    function automatic void push_number();
        int n_digits;
        int sel;
        sel = $urandom_range(0, 9);
        n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 13) : $urandom_range(1, 4);
        if (sel < 2)
            tx_q.push_back({1'b0, hrhp_pkg::CH_MINUS});
        else if (sel == 2)
            tx_q.push_back({1'b0, hrhp_pkg::CH_PLUS});
        else if (sel == 3)
        begin
            // minus zero
            push_text("-0");
            n_digits = 0;
        end
        for (int i = 0; i < n_digits; i++)
            tx_q.push_back({1'b0, 8'h30 + 8'($urandom_range(0, 9))});
        if ($urandom_range(0, 3) == 0)
            push_text(" OK");
    endfunction

    function automatic void push_clen_name();
        logic [7:0] ch;
        int         broken;
        broken = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 14) : -1;
        for (int i = 0; i < 15; i++)
        begin
            ch = CLEN_TEXT[8*(14-i) +: 8];
            if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1)
                ch = ch + 8'd32;
            if (i == broken)
                ch = "X";
            tx_q.push_back({1'b0, ch});
        end
    endfunction

    task automatic send_item(input logic op, input logic [7:0] octet,
                             input logic typed, input hrhp_pkg::result_t fixed);
        int                gap;
        hrhp_pkg::result_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= octet;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = parse_octet(op, octet);
        outcome_q.push_back(typed ? fixed : predicted);
        sent_count++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver back-pressure: rotate a 16-bit pattern, reloaded when ready_left runs out
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pat = 16'hFFFF;
                1:       ready_pat = 16'($urandom) | 16'h0001;
                2:       ready_pat = 16'h8888;
                default: ready_pat = 16'h00FF;
            endcase
            ready_left = 32;
        end
        m_tready <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[15:1]};
        ready_left--;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind           = m_tuser;
            got.status_code    = m_tdata[15:0];
            got.content_length = m_tdata[46:16];
            got.body_byte      = m_tdata[54:47];
            if (outcome_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result kind %0d status %0d length %0d body %h",
                         $time, got.kind, $signed(got.status_code), got.content_length,
                         got.body_byte);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    $display({"%0t: mismatch kind %0d/%0d status %0d/%0d length %0d/%0d",
                              " body %h/%h (expected/actual)"},
                             $time, want.kind, got.kind,
                             $signed(want.status_code), $signed(got.status_code),
                             want.content_length, got.content_length,
                             want.body_byte, got.body_byte);
                end
            end
        end
    end

    // watchdog: count cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int flavour;
        int n_hdr;
        int pick;
        int cut;
        int resp_count;
        logic [7:0] ch;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        resp_count = 0;
        parse_reset();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            send_item(DIRECTED[i].op, DIRECTED[i].octet, DIRECTED[i].typed, DIRECTED[i].want);
        send_item(1'b1, 8'h00, 1'b0, '0);

        while (sent_count < RANDOM_ITEMS + N_ROWS)
        begin
            tx_q.delete();
            flavour = $urandom_range(0, 9);
            if (flavour == 0)
            begin
                // raw noise, CR and LF included
                repeat ($urandom_range(1, 24))
                    tx_q.push_back({1'b0, 8'($urandom)});
            end
            else
            begin
                if (flavour == 1)
                    push_text("HTTP/1.0 200");
                else if (flavour == 2)
                    push_text("http/1.1 200");
                else
                begin
                    push_text("HTTP/1.1");
                    push_ws();
                    push_number();
                end
                push_eol();
                n_hdr = $urandom_range(0, 3);
                for (int h = 0; h < n_hdr; h++)
                begin
                    pick = $urandom_range(0, 39);
                    if (pick == 0)
                    begin
                        // number lands across the end of the line buffer
                        push_clen_name();
                        repeat ($urandom_range(230, 245))
                            tx_q.push_back({1'b0, 8'd32});
                        push_number();
                    end
                    else if (pick == 1)
                    begin
                        repeat ($urandom_range(250, 300))
                            tx_q.push_back({1'b0, 8'($urandom_range(32, 126))});
                    end
                    else if (pick < 22)
                    begin
                        push_clen_name();
                        push_ws();
                        push_number();
                    end
                    else
                    begin
                        repeat ($urandom_range(0, 12))
                        begin
                            if ($urandom_range(0, 19) == 0)
                                ch = $urandom_range(0, 1) ? hrhp_pkg::CH_CR : hrhp_pkg::CH_LF;
                            else
                                ch = 8'($urandom_range(32, 126));
                            tx_q.push_back({1'b0, ch});
                        end
                    end
                    push_eol();
                end
                if ($urandom_range(0, 9) != 0)
                    push_eol();
                repeat ($urandom_range(0, 16))
                    tx_q.push_back({1'b0, 8'($urandom)});
                if ($urandom_range(0, 9) == 0)
                begin
                    // drop the tail: restart mid-response
                    cut = $urandom_range(0, tx_q.size());
                    while (tx_q.size() > cut)
                        void'(tx_q.pop_back());
                end
            end
            tx_q.push_back({1'b1, 8'($urandom)});
            foreach (tx_q[i])
                send_item(tx_q[i][8], tx_q[i][7:0], 1'b0, '0);
            if (resp_count == 3 || $urandom_range(0, 14) == 0)
                wait_drained();
            resp_count++;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/hrhp_pkg.sv
hdl/hrhp_step.sv
hdl/http_response_header_parser.sv
hdl/hrhp_checker.sv
test/http_response_header_parser_tb.sv
